/* design/sha256_pkg.sv */
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMPRESS,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load_byte;
    logic       step;
    logic [7:0] data;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } round_ctrl_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* design/sha256_msg_sched.sv */
module sha256_msg_sched (
  input  logic                    clk,
  input  sha256_pkg::sched_ctrl_t ctrl,
  output sha256_pkg::word_t       w
);
  import sha256_pkg::*;

  // Sixteen-word window, oldest word in the top bits. Bytes shift in at the
  // bottom while a block fills; during rounds it slides one word per cycle.
  logic [511:0] blk;
  word_t        new_w;

  assign w = blk[511:480];

  assign new_w = blk[511:480] + small_sigma0(blk[479:448]) + blk[223:192]
               + small_sigma1(blk[63:32]);

  always_ff @(posedge clk) begin
    if (ctrl.load_byte) begin
      blk <= {blk[503:0], ctrl.data};
    end else if (ctrl.step) begin
      blk <= {blk[479:0], new_w};
    end
  end

endmodule

/* design/sha256_round.sv */
module sha256_round (
  input  logic                    clk,
  input  sha256_pkg::round_ctrl_t ctrl,
  input  sha256_pkg::hash_t       init_v,
  input  sha256_pkg::word_t       w,
  input  sha256_pkg::word_t       k,
  output sha256_pkg::hash_t       v
);
  import sha256_pkg::*;

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + big_sigma1(v[4]) + ch + k + w;
  assign t2  = big_sigma0(v[0]) + maj;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v <= init_v;
    end else if (ctrl.step) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
  end

endmodule

/* design/sha256_stream_hasher.sv */
// SHA-256 hasher for a byte stream.
// The input channel (in_valid/in_ready) carries one transaction per message
// byte: data_byte is taken when byte_present is high, and end_of_message
// closes the message; a transaction may carry only the end mark, so an empty
// message hashes correctly. The output channel (out_valid/out_ready) carries
// one transaction per message with the eight digest words, digest_w0 first.
// A byte that does not complete a 64-byte block is shifted into the window.
// A byte that completes a block starts its compression: one round per cycle
// through the single shared round unit, then a step that adds into the hash words.
// After the end mark, padding is shifted into the block window one byte per
// cycle, then each padding block takes 64 rounds and one hash-update step;
// one or two padding blocks are needed, and a last step loads the digest
// register.
// in_ready is high only while the sequencer is idle.
// The digest sits in an output register; the block keeps taking bytes of the
// next message while the receiver stalls, and waits only when a second digest
// is ready before the first was taken.
// Synchronous reset returns to the initial hash state with an empty message
// and no pending digest.
module sha256_stream_hasher (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                end_of_message,
  output logic                out_valid,
  input  logic                out_ready,
  output sha256_pkg::word_t   digest_w0,
  output sha256_pkg::word_t   digest_w1,
  output sha256_pkg::word_t   digest_w2,
  output sha256_pkg::word_t   digest_w3,
  output sha256_pkg::word_t   digest_w4,
  output sha256_pkg::word_t   digest_w5,
  output sha256_pkg::word_t   digest_w6,
  output sha256_pkg::word_t   digest_w7
);
  import sha256_pkg::*;

  state_t      state, state_next;
  logic [5:0]  fill, fill_next;
  logic [63:0] len, len_next;
  logic [5:0]  round, round_next;
  // ending: the end mark has arrived and its digest is not yet out.
  // mark_done: the 0x80 byte is already in the window.
  // two_block: the 0x80 landed too late for the length, so one more block follows.
  logic        ending, ending_next;
  logic        mark_done, mark_done_next;
  logic        two_block, two_block_next;
  hash_t       hash, hash_next;
  hash_t       dig, dig_next;
  logic        out_valid_next;

  sched_ctrl_t sctrl;
  round_ctrl_t rctrl;
  word_t       w;
  hash_t       v;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;

  sha256_msg_sched u_sched (
    .clk  (clk),
    .ctrl (sctrl),
    .w    (w)
  );

  sha256_round u_round (
    .clk    (clk),
    .ctrl   (rctrl),
    .init_v (hash),
    .w      (w),
    .k      (ROUND_K[round]),
    .v      (v)
  );

  // Length bytes go out big-endian in the last eight positions of the block.
  assign len_byte = len[{~fill[2:0], 3'b000} +: 8];

  always_comb begin
    if (!mark_done) begin
      pad_byte = PAD_MARK;
    end else if (fill >= LEN_POS && !two_block) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    len_next       = len;
    round_next     = round;
    ending_next    = ending;
    mark_done_next = mark_done;
    two_block_next = two_block;
    hash_next      = hash;
    dig_next       = dig;
    out_valid_next = out_valid;
    sctrl          = '0;
    sctrl.data     = data_byte;
    rctrl          = '0;
    in_ready       = (state == ST_IDLE);

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (byte_present) begin
            sctrl.load_byte = 1'b1;
            fill_next       = fill + 6'd1;
            len_next        = len + 64'd8;
          end
          if (end_of_message) begin
            ending_next = 1'b1;
          end
          if (byte_present && fill == LAST_POS) begin
            rctrl.load = 1'b1;
            round_next = '0;
            state_next = ST_COMPRESS;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sctrl.load_byte = 1'b1;
        sctrl.data      = pad_byte;
        fill_next       = fill + 6'd1;
        if (!mark_done) begin
          mark_done_next = 1'b1;
          two_block_next = (fill >= LEN_POS);
        end
        if (fill == LAST_POS) begin
          rctrl.load = 1'b1;
          round_next = '0;
          state_next = ST_COMPRESS;
        end
      end
      ST_COMPRESS: begin
        rctrl.step = 1'b1;
        sctrl.step = 1'b1;
        round_next = round + 6'd1;
        if (round == LAST_ROUND) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          hash_next[i] = hash[i] + v[i];
        end
        if (!ending) begin
          state_next = ST_IDLE;
        end else if (mark_done && !two_block) begin
          state_next = ST_DONE;
        end else begin
          two_block_next = 1'b0;
          state_next     = ST_PAD;
        end
      end
      ST_DONE: begin
        // Hold here only while an earlier digest still waits to be taken.
        if (!out_valid || out_ready) begin
          dig_next       = hash;
          out_valid_next = 1'b1;
          hash_next      = INIT_HASH;
          fill_next      = '0;
          len_next       = '0;
          ending_next    = 1'b0;
          mark_done_next = 1'b0;
          two_block_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      len       <= '0;
      round     <= '0;
      ending    <= 1'b0;
      mark_done <= 1'b0;
      two_block <= 1'b0;
      hash      <= INIT_HASH;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      len       <= len_next;
      round     <= round_next;
      ending    <= ending_next;
      mark_done <= mark_done_next;
      two_block <= two_block_next;
      hash      <= hash_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    dig <= dig_next;
  end

  assign digest_w0 = dig[0];
  assign digest_w1 = dig[1];
  assign digest_w2 = dig[2];
  assign digest_w3 = dig[3];
  assign digest_w4 = dig[4];
  assign digest_w5 = dig[5];
  assign digest_w6 = dig[6];
  assign digest_w7 = dig[7];

endmodule

/* test/sha256_stream_hasher_test.sv */
module sha256_stream_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::word_t;
  import sha256_pkg::hash_t;

  // Run limits. A correct run ends well short of the cycle limit.
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int ITEM_TARGET    = 2000;
  localparam int MESSAGE_TARGET = 40;
  localparam int LONG_HOLD      = 1500;
  localparam int DRAIN_CYCLES   = 300;
  localparam int REPORT_LIMIT   = 10;

  // Round constants and initial hash words of SHA-256, kept here so that the
  // prediction does not lean on the tables inside the design.
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // The checker keeps its own copy of the hashing state. Every accepted
  // input transaction is absorbed into it, and every message end pushes the
  // digest that the block must produce for that message.
  class sha256_digest_checker;
    logic [7:0]  block_bytes [64];
    word_t       chain [8];
    logic [5:0]  fill;
    logic [63:0] bit_len;
    hash_t       expected_digests [$];
    int          mismatches;

    function new();
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = SHA_H0[i];
      fill = 6'd0;
      bit_len = 64'd0;
    endfunction

    function word_t ror(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of the current block into the chain words.
    function void compress();
      word_t sched [64];
      word_t v [8];
      word_t t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) begin
        sched[i] = {block_bytes[4 * i], block_bytes[4 * i + 1],
                    block_bytes[4 * i + 2], block_bytes[4 * i + 3]};
      end
      for (int i = 16; i < 64; i++) begin
        s0 = ror(sched[i - 15], 7) ^ ror(sched[i - 15], 18) ^ (sched[i - 15] >> 3);
        s1 = ror(sched[i - 2], 17) ^ ror(sched[i - 2], 19) ^ (sched[i - 2] >> 10);
        sched[i] = sched[i - 16] + s0 + sched[i - 7] + s1;
      end
      foreach (v[i]) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] = chain[i] + v[i];
    endfunction

    // Notes one accepted input transaction.
    function void absorb_item(logic [7:0] data, logic present, logic last);
      int    pos;
      hash_t digest;
      if (present) begin
        block_bytes[fill] = data;
        fill = fill + 6'd1;
        bit_len = bit_len + 64'd8;
        if (fill == 6'd0) compress();
      end
      if (!last) return;
      // Padding: the marker byte, zeros, and the big-endian bit length.
      // When the length no longer fits behind the marker, an extra block
      // of padding is compressed first.
      pos = fill;
      block_bytes[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8 * i +: 8];
      compress();
      for (int i = 0; i < 8; i++) digest[i] = chain[i];
      expected_digests.push_back(digest);
      restart();
    endfunction

    function int pending();
      return expected_digests.size();
    endfunction

    // Compares one accepted output transaction with the oldest expected digest.
    function void check_digest(hash_t actual);
      hash_t wanted;
      if (expected_digests.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected digest at %0t: w0=%08h", $realtime, actual[0]);
        return;
      end
      wanted = expected_digests.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (actual[i] !== wanted[i]) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("digest_w%0d mismatch at %0t: expected %08h, actual %08h",
                     i, $realtime, wanted[i], actual[i]);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  logic       out_valid;
  logic       out_ready;
  word_t      digest_w0;
  word_t      digest_w1;
  word_t      digest_w2;
  word_t      digest_w3;
  word_t      digest_w4;
  word_t      digest_w5;
  word_t      digest_w6;
  word_t      digest_w7;

  sha256_digest_checker hasher = new();

  // Shared controls of the stimulus. The calm flag switches off idling on
  // both sides; the hold request asks the receiver for a long stall.
  bit calm;
  bit hold_request;
  int items_sent;
  int messages_sent;
  int cycles;

  sha256_stream_hasher i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_w0      (digest_w0),
    .digest_w1      (digest_w1),
    .digest_w2      (digest_w2),
    .digest_w3      (digest_w3),
    .digest_w4      (digest_w4),
    .digest_w5      (digest_w5),
    .digest_w6      (digest_w6),
    .digest_w7      (digest_w7)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle gap in cycles: mostly short, sometimes medium, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  // Drops valid at the next falling edge so that the last transaction is not
  // taken a second time while the sender waits for something else.
  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Offers one input transaction, after an optional gap, and holds it until
  // the block takes it. The task returns right after the accepting edge, so
  // a following call with no gap keeps valid high without a dip.
  task automatic send_item(logic [7:0] data, logic present, logic last);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = data;
    byte_present = present;
    end_of_message = last;
    do @(posedge clk); while (!in_ready);
    hasher.absorb_item(data, present, last);
    if (present || last) items_sent++;
  endtask

  // Sends one message of the given length. Ignored transactions are mixed
  // in now and then, and the end mark either rides on the last byte or
  // comes as a transaction of its own.
  task automatic send_message(int len);
    bit end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
    messages_sent++;
  endtask

  // Message length: many short ones, lengths around the block and padding
  // boundaries, some medium, and a few spanning several blocks.
  function automatic int pick_length();
    int roll;
    int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 10);
    if (roll < 65) return edges[$urandom_range(0, 9)];
    if (roll < 90) return $urandom_range(11, 100);
    return $urandom_range(129, 300);
  endfunction

  // The sender stops until every digest that is owed has been taken.
  task automatic wait_drained();
    idle_input();
    while (hasher.pending() != 0) @(posedge clk);
  endtask

  // Receiver: out_ready follows random runs and gaps, counted in cycles
  // here, and a hold request turns into one long stall.
  initial begin
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) gap_left = pick_gap();
      end
    end
  end

  // Output monitor: every accepted output transaction is checked.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        hasher.check_digest({digest_w7, digest_w6, digest_w5, digest_w4,
                             digest_w3, digest_w2, digest_w1, digest_w0});
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    byte_present = 1'b0;
    end_of_message = 1'b0;
    calm = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    messages_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. The empty message first, straight out of reset.
    send_item(8'h00, 1'b0, 1'b1);
    // A short text message whose end mark rides on its last byte.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Ignored transactions carrying junk data between the extreme bytes,
    // then an end mark on its own.
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b1);
    // Single-byte messages with the extreme values, and two empty messages
    // back to back.
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    wait_drained();

    // Back pressure: the receiver stalls for a long stretch while short
    // messages keep coming, so the output register fills and the block
    // has to hold off its input.
    hold_request = 1'b1;
    calm = 1'b1;
    for (int i = 0; i < 12; i++) send_message($urandom_range(0, 3));
    calm = 1'b0;
    wait_drained();

    // Random part.
    while (items_sent < ITEM_TARGET || messages_sent < MESSAGE_TARGET) begin
      calm = ($urandom_range(0, 5) == 0);
      send_message(pick_length());
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    calm = 1'b0;
    wait_drained();

    // Let any stray output show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hasher.mismatches == 0 && hasher.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
